[rtl/core/swm_pkg.sv]
// Shared constants and types for the sliding-window median filter.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none
package swm_pkg;

  localparam int MAX_WINDOW   = 64;
  localparam int SAMPLE_WIDTH = 32;
  localparam int IDX_W        = $clog2(MAX_WINDOW);
  localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
  localparam int OUT_W        = SAMPLE_WIDTH + 1;
  localparam int DEFAULT_SIZE = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [OUT_W-1:0]        median_t;
  typedef logic        [CNT_W-1:0]        count_t;
  typedef logic        [IDX_W-1:0]        age_t;

  // Contents one cell shows to its neighbors.
  typedef struct packed {
    sample_t val;
    age_t    age;
    logic    gt;      // value above the incoming sample, or cell empty
  } cell_t;

  // Broadcast from the control logic to every cell.
  typedef struct packed {
    logic    load;
    sample_t x;
    count_t  fill;
    logic    full;
    age_t    oldest_age;
  } cell_ctl_t;

endpackage
`default_nettype wire

[rtl/core/swm_in_if.sv]
// Input channel of the median filter: sample and restart flag.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface swm_in_if
  import swm_pkg::*;
;
  logic    valid;
  logic    ready;
  sample_t sample;
  logic    restart;

  modport source (output valid, output sample, output restart, input ready);
  modport sink   (input valid, input sample, input restart, output ready);
endinterface
`default_nettype wire

[rtl/core/swm_out_if.sv]
// Output channel of the median filter: doubled median.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none
interface swm_out_if
  import swm_pkg::*;
;
  logic    valid;
  logic    ready;
  median_t median_doubled;

  modport source (output valid, output median_doubled, input ready);
  modport sink   (input valid, input median_doubled, output ready);
endinterface
`default_nettype wire

[rtl/core/sliding_window_median.sv]
// Top level of the sliding-window median filter: control, cell chain, output.
// Depends on swm_pkg, swm_in_if, swm_out_if, swm_cell, swm_pick.
//
//  channel  dir  payload                      handshake
//  in_ch    in   sample[31:0] s, restart      valid/ready
//  out_ch   out  median_doubled[32:0] s       valid/ready
//  cfg      in   cfg_wdata[6:0] window_size   cfg_we
//
// One sample per cycle, unless a stalled output holds in_ch.ready low; the cell
// chain rewrites the sorted window on each accepted sample. A result passes the
// cell update, then middle select and add into the output register.
// rst (synchronous) empties the window and sets the size to 3.
// A stalled output holds at most one more result pending in the cells.
`timescale 1ns / 1ps
`default_nettype none
module sliding_window_median
  import swm_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [6:0]   cfg_wdata,
  swm_in_if.sink            in_ch,
  swm_out_if.source         out_ch
);

  count_t    size;
  count_t    size_next;
  count_t    fill;
  count_t    fill_eff;
  logic      pending;
  logic      accept;
  logic      full;
  logic      emit;
  logic      take;
  logic      free;
  cell_ctl_t ctl;
  cell_t     cells [MAX_WINDOW];
  logic      rm    [MAX_WINDOW+1];
  sample_t   vals  [MAX_WINDOW];

  always_comb begin
    if (cfg_wdata == '0) begin
      size_next = count_t'(1);
    end else if (CNT_W'(cfg_wdata) > count_t'(MAX_WINDOW)) begin
      size_next = count_t'(MAX_WINDOW);
    end else begin
      size_next = CNT_W'(cfg_wdata);
    end
  end

  assign accept   = in_ch.valid && in_ch.ready;
  assign fill_eff = (in_ch.restart || fill > size) ? '0 : fill;
  assign full     = fill_eff == size;
  assign emit     = full || (fill_eff + count_t'(1) == size);
  assign take     = pending && free;
  assign in_ch.ready = !pending || free;

  assign ctl.load       = accept;
  assign ctl.x          = in_ch.sample;
  assign ctl.fill       = fill_eff;
  assign ctl.full       = full;
  assign ctl.oldest_age = IDX_W'(size - count_t'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      size    <= count_t'(DEFAULT_SIZE);
      fill    <= '0;
      pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        size <= size_next;
        fill <= '0;
      end else if (accept) begin
        fill <= full ? fill_eff : fill_eff + count_t'(1);
      end
      if (accept) begin
        pending <= emit;
      end else if (take) begin
        pending <= 1'b0;
      end
    end
  end

  assign rm[0] = 1'b0;

  for (genvar i = 0; i < MAX_WINDOW; i++) begin : g_cell
    cell_t left;
    cell_t right;
    if (i == 0) begin : g_first
      assign left = '{val: '0, age: '0, gt: 1'b0};
    end else begin : g_mid_l
      assign left = cells[i-1];
    end
    if (i == MAX_WINDOW - 1) begin : g_last
      assign right = '{val: '0, age: '0, gt: 1'b1};
    end else begin : g_mid_r
      assign right = cells[i+1];
    end

    swm_cell u_cell (
      .clk    (clk),
      .ctl    (ctl),
      .pos    (IDX_W'(i)),
      .left   (left),
      .right  (right),
      .rm_in  (rm[i]),
      .rm_out (rm[i+1]),
      .self   (cells[i])
    );

    assign vals[i] = cells[i].val;
  end

  swm_pick u_pick (
    .clk    (clk),
    .rst    (rst),
    .size   (size),
    .take   (take),
    .vals   (vals),
    .free   (free),
    .out_ch (out_ch)
  );

endmodule
`default_nettype wire

[rtl/core/swm_cell.sv]
// One slot of the sorted window: value and age, updated from its neighbors.
// Depends on swm_pkg.
`timescale 1ns / 1ps
`default_nettype none
module swm_cell
  import swm_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire age_t      pos,
  input  wire cell_t     left,
  input  wire cell_t     right,
  input  wire logic      rm_in,
  output logic           rm_out,
  output cell_t          self
);

  sample_t val;
  age_t    age;
  logic    live;
  logic    del;
  cell_t   cur;
  cell_t   prv;

  assign live = {1'b0, pos} < ctl.fill;
  assign self.val = val;
  assign self.age = age;
  assign self.gt  = !live || (val > ctl.x);
  assign del    = ctl.full && live && (age == ctl.oldest_age);
  assign rm_out = rm_in || del;

  // compacted list after removal: entry at this slot and the one below
  assign cur = rm_out ? right : self;
  assign prv = rm_in  ? self  : left;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      if (!cur.gt) begin
        val <= cur.val;
        age <= cur.age + age_t'(1);
      end else if (!prv.gt) begin
        val <= ctl.x;
        age <= '0;
      end else begin
        val <= prv.val;
        age <= prv.age + age_t'(1);
      end
    end
  end

endmodule
`default_nettype wire

[rtl/core/swm_pick.sv]
// Selects the middle cell(s), forms the doubled median, holds the output.
// Depends on swm_pkg and swm_out_if.
`timescale 1ns / 1ps
`default_nettype none
module swm_pick
  import swm_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire count_t  size,
  input  wire logic    take,
  input  wire sample_t vals [MAX_WINDOW],
  output logic         free,
  swm_out_if.source    out_ch
);

  count_t  hi_idx;
  count_t  lo_idx;
  sample_t lo_val;
  sample_t hi_val;
  logic    valid;
  median_t median;

  assign hi_idx = size >> 1;
  assign lo_idx = size[0] ? hi_idx : hi_idx - count_t'(1);

  always_comb begin
    lo_val = '0;
    hi_val = '0;
    for (int i = 0; i < MAX_WINDOW; i++) begin
      if (lo_idx == count_t'(i)) lo_val = lo_val | vals[i];
      if (hi_idx == count_t'(i)) hi_val = hi_val | vals[i];
    end
  end

  assign free = !valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (out_ch.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      median <= median_t'(lo_val) + median_t'(hi_val);
    end
  end

  assign out_ch.valid          = valid;
  assign out_ch.median_doubled = median;

endmodule
`default_nettype wire

[dv/tb_sliding_window_median.sv]
`timescale 1ns / 1ps
// Self-checking testbench for sliding_window_median: a queue-fed driver and a monitor
// with random gaps and stalls, and a behavioral window model that predicts each median.
// Depends on swm_pkg, swm_in_if, swm_out_if and the sliding_window_median RTL.
module tb_sliding_window_median;
  import swm_pkg::*;

  typedef struct {
    sample_t sample;
    logic    restart;
  } feed_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [6:0] cfg_wdata;

  swm_in_if  in_ch ();
  swm_out_if out_ch ();

  sliding_window_median DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  feed_t   pending_q[$];
  median_t median_q[$];
  int      errors;

  // window model
  sample_t    win_ring[MAX_WINDOW];
  sample_t    win_sorted[MAX_WINDOW];
  int         win_fill;
  int         win_oldest;
  logic [6:0] win_size;

  int in_gap, in_stretch, out_gap, out_stretch;
  bit in_calm, out_calm;

  task automatic report_mismatch(input string what);
    $display("%0t ns: %s", $time, what);
    errors++;
  endtask

  // wait length for one transaction; runs of gapless transactions now and then
  function automatic int pick_wait(inout int stretch, inout bit calm);
    if (stretch <= 0) begin
      calm = ($urandom_range(0, 2) == 0);
      stretch = $urandom_range(10, 40);
    end
    stretch--;
    return calm ? 0 : $urandom_range(0, 9);
  endfunction

  function automatic int effective_size();
    if (win_size == 0) return 1;
    if (win_size > MAX_WINDOW) return MAX_WINDOW;
    return int'(win_size);
  endfunction

  task automatic sorted_drop(input sample_t v, input int n);
    int i;
    i = 0;
    while (i < n && win_sorted[i] != v) i++;
    if (i < n) begin
      for (; i + 1 < n; i++) win_sorted[i] = win_sorted[i + 1];
    end
  endtask

  task automatic sorted_add(input sample_t v, input int n);
    int i;
    i = n;
    if (n < MAX_WINDOW) begin
      while (i > 0 && win_sorted[i - 1] > v) begin
        win_sorted[i] = win_sorted[i - 1];
        i--;
      end
      win_sorted[i] = v;
    end
  endtask

  task automatic advance_window(input sample_t x, input logic restart, output bit has,
                                output median_t med);
    int k, slot;
    sample_t a, b;
    k = effective_size();
    has = 1'b0;
    med = '0;
    if (restart || win_fill > k) begin
      win_fill = 0;
      win_oldest = 0;
    end
    if (win_fill < k) begin
      slot = win_oldest + win_fill;
      if (slot >= k) slot -= k;
      win_ring[slot] = x;
      sorted_add(x, win_fill);
      win_fill++;
      if (win_fill < k) return;
    end else begin
      slot = (win_oldest >= k) ? 0 : win_oldest;
      sorted_drop(win_ring[slot], k);
      sorted_add(x, k - 1);
      win_ring[slot] = x;
      slot++;
      if (slot >= k) slot = 0;
      win_oldest = slot;
    end
    if (k % 2 == 1) begin
      a = win_sorted[k / 2];
      b = a;
    end else begin
      a = win_sorted[k / 2 - 1];
      b = win_sorted[k / 2];
    end
    med = {a[SAMPLE_WIDTH-1], a} + {b[SAMPLE_WIDTH-1], b};
    has = 1'b1;
  endtask

  task automatic push_item(input sample_t s, input logic r);
    feed_t f;
    f.sample = s;
    f.restart = r;
    pending_q = {pending_q, f};
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'({1'b0, {(SAMPLE_WIDTH-1){1'b1}}});
      1: return sample_t'({1'b1, {(SAMPLE_WIDTH-1){1'b0}}});
      2, 3: return sample_t'($signed($urandom_range(0, 6)) - 3);
      4: return sample_t'($urandom_range(0, 15)) ^ {SAMPLE_WIDTH{$urandom_range(0, 1) == 1}};
      default: return sample_t'($urandom);
    endcase
  endfunction

  // waits until every transaction has drained, then covers the pipeline latency
  task automatic drain();
    while (pending_q.size() != 0 || in_ch.valid || median_q.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_size(input logic [6:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    win_size = v;
    win_fill = 0;
    win_oldest = 0;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic random_phase(input logic [6:0] size, input int count);
    write_size(size);
    for (int i = 0; i < count; i++)
      push_item(random_sample(), $urandom_range(0, 39) == 0);
    drain();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.restart = 1'b0;
    out_ch.ready = 1'b0;
    errors = 0;
    win_size = 7'(DEFAULT_SIZE);
    win_fill = 0;
    win_oldest = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset size: extremes, duplicates, restart mid-stream
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh0000_0000, 1'b0);
    push_item(32'shFFFF_FFFF, 1'b0);
    push_item(32'sh0000_0001, 1'b0);
    repeat (4) push_item(32'sh0000_0005, 1'b0);
    push_item(32'sh0000_0009, 1'b1);
    push_item(32'sh0000_0002, 1'b0);
    push_item(32'sh0000_0003, 1'b0);
    drain();

    // even size: sums of the extremes
    write_size(7'd2);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh8000_0000, 1'b0);
    push_item(32'sh7FFF_FFFF, 1'b0);
    drain();

    random_phase(7'd0, 25);
    random_phase(7'd1, 25);
    random_phase(7'd2, 25);
    random_phase(7'd3, 30);
    random_phase(7'd4, 25);
    random_phase(7'd5, 25);
    random_phase(7'd6, 25);
    random_phase(7'd7, 25);
    random_phase(7'd8, 30);
    random_phase(7'd64, 90);
    random_phase(7'd127, 70);
    random_phase(7'd100, 70);
    random_phase(7'd2, 25);

    if (errors == 0) begin
      $display("sliding_window_median: match");
    end else begin
      $display("sliding_window_median: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("sliding_window_median: mismatch");
    $finish;
  end

  // driver
  always @(posedge clk) begin : feed_proc
    bit      fire, has;
    int      g;
    median_t med;
    feed_t   f;
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_ch.sample <= '0;
      in_ch.restart <= 1'b0;
      in_gap <= 0;
    end else begin
      fire = in_ch.valid && in_ch.ready;
      if (fire) begin
        advance_window(in_ch.sample, in_ch.restart, has, med);
        if (has) median_q = {median_q, med};
      end
      if (!in_ch.valid || fire) begin
        g = fire ? pick_wait(in_stretch, in_calm) : in_gap;
        if (g == 0 && pending_q.size() != 0) begin
          f = pending_q.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.sample <= f.sample;
          in_ch.restart <= f.restart;
          in_gap <= 0;
        end else begin
          in_ch.valid <= 1'b0;
          in_gap <= (g > 0) ? g - 1 : 0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin : sink_proc
    bit      fire;
    int      g;
    median_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_gap <= 0;
    end else begin
      fire = out_ch.valid && out_ch.ready;
      if (fire) begin
        if (median_q.size() == 0) begin
          report_mismatch($sformatf("unexpected median_doubled %h",
                                    out_ch.median_doubled));
        end else begin
          want = median_q.pop_front();
          if (out_ch.median_doubled !== want)
            report_mismatch($sformatf("median_doubled %h, predicted %h",
                                      out_ch.median_doubled, want));
        end
      end
      if (fire || !out_ch.ready) begin
        g = fire ? pick_wait(out_stretch, out_calm) : out_gap;
        if (g == 0) begin
          out_ch.ready <= 1'b1;
        end else begin
          out_ch.ready <= 1'b0;
          out_gap <= g - 1;
        end
      end
    end
  end

endmodule

[sliding_window_median.f]
rtl/core/swm_pkg.sv
rtl/core/swm_in_if.sv
rtl/core/swm_out_if.sv
rtl/core/swm_cell.sv
rtl/core/swm_pick.sv
rtl/core/sliding_window_median.sv
dv/tb_sliding_window_median.sv
